>>> rtl/smallest_factor_sieve_top_defines.svh
// assertion macros for the smallest factor sieve
// expects clk_i and rst_ni in the scope of each use
`ifndef SMALLEST_FACTOR_SIEVE_TOP_DEFINES_SVH
`define SMALLEST_FACTOR_SIEVE_TOP_DEFINES_SVH

// check that holds in the same cycle, off during reset
`define SFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that relates a cycle to the following one
`define SFS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/sfs_pkg.sv
// types, codes and microcode rom of the smallest factor sieve
// no dependencies
package sfs_pkg;

  localparam int unsigned ADDR_W = 12;
  localparam int unsigned LIM_W  = 13;
  localparam int unsigned UPC_W  = 4;

  localparam logic [LIM_W-1:0] MAX_LIMIT   = 13'd4096;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 13'd4096;

  // input opcodes
  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BUILT     = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  typedef logic [UPC_W-1:0] upc_t;

  // microprogram step addresses
  localparam upc_t UPC_IDLE   = 4'd0;
  localparam upc_t UPC_CLR    = 4'd1;
  localparam upc_t UPC_SET2   = 4'd2;
  localparam upc_t UPC_OTEST  = 4'd3;
  localparam upc_t UPC_OCHK   = 4'd4;
  localparam upc_t UPC_PRIME  = 4'd5;
  localparam upc_t UPC_JINIT  = 4'd6;
  localparam upc_t UPC_JTEST  = 4'd7;
  localparam upc_t UPC_JCHK   = 4'd8;
  localparam upc_t UPC_INEXT  = 4'd9;
  localparam upc_t UPC_DONE   = 4'd10;
  localparam upc_t UPC_QRES   = 4'd11;

  // datapath actions
  typedef enum logic [3:0] {
    A_NONE,
    A_CLR,    // zero entry i when below limit, step i
    A_I2,     // start outer walk at 2
    A_RDI,    // read entry i, square i
    A_WRI,    // entry i holds itself
    A_JSQ,    // j starts at i*i
    A_RDJ,    // read entry j
    A_MARK,   // mark entry j with i when still empty, step j by i
    A_INC,    // next i
    A_BEMIT,  // emit build done result
    A_QEMIT   // emit query result
  } act_e;

  // sequencer branch conditions
  typedef enum logic [3:0] {
    C_NEXT,
    C_JUMP,
    C_ITEM,
    C_I_LT_LIM,
    C_I_GE_LIM,
    C_RD_NZ,
    C_SQ_GE_LIM,
    C_J_GE_LIM,
    C_EMIT
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    upc_t  target;
  } ctrl_t;

  // control store
  function automatic ctrl_t ucode_rom(upc_t addr);
    ctrl_t w;
    case (addr)
      UPC_IDLE:  w = '{act: A_NONE,  cond: C_ITEM,      target: UPC_IDLE};
      UPC_CLR:   w = '{act: A_CLR,   cond: C_I_LT_LIM,  target: UPC_CLR};
      UPC_SET2:  w = '{act: A_I2,    cond: C_NEXT,      target: UPC_IDLE};
      UPC_OTEST: w = '{act: A_RDI,   cond: C_I_GE_LIM,  target: UPC_DONE};
      UPC_OCHK:  w = '{act: A_NONE,  cond: C_RD_NZ,     target: UPC_INEXT};
      UPC_PRIME: w = '{act: A_WRI,   cond: C_SQ_GE_LIM, target: UPC_INEXT};
      UPC_JINIT: w = '{act: A_JSQ,   cond: C_NEXT,      target: UPC_IDLE};
      UPC_JTEST: w = '{act: A_RDJ,   cond: C_J_GE_LIM,  target: UPC_INEXT};
      UPC_JCHK:  w = '{act: A_MARK,  cond: C_JUMP,      target: UPC_JTEST};
      UPC_INEXT: w = '{act: A_INC,   cond: C_JUMP,      target: UPC_OTEST};
      UPC_DONE:  w = '{act: A_BEMIT, cond: C_EMIT,      target: UPC_IDLE};
      UPC_QRES:  w = '{act: A_QEMIT, cond: C_EMIT,      target: UPC_IDLE};
      default:   w = '{act: A_NONE,  cond: C_JUMP,      target: UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/smallest_factor_sieve_top.sv
// Smallest prime factor table with lookups. A build transaction (tuser 0)
// clears entries below min(table_limit, 4096) of a 4096 x 12 bit table and
// fills them with an Eratosthenes sieve; a query transaction (tuser 1)
// returns the factor of one number, a prime flag and a status. A query
// reads the table at acceptance and registers the result in the QRES step
// as soon as the result register is free. A build runs on a microcoded
// sequencer with one write and one read port on the table: it clears the
// table, then for each i from 2 below L reads entry i, writes i to it when
// it is empty (i is prime) and, when i*i is below L, marks each empty
// multiple of i from i*i on with i, and at the end emits one result (L the
// saturated limit); input ready is low for that time. A result register
// lets the next transaction in while a result waits at the output.
// Depends on sfs_pkg and smallest_factor_sieve_top_defines.svh.

`include "smallest_factor_sieve_top_defines.svh"

module smallest_factor_sieve_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] query_number, [15:12] zero
  input  logic [0:0]  s_axis_tuser,   // [0] opcode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] smallest_factor, [12] is_prime, [15:13] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import sfs_pkg::*;

  localparam int unsigned DEPTH = 1 << ADDR_W;

  // control state
  upc_t              upc_q, upc_d;
  logic              built_q;
  logic [LIM_W-1:0]  built_lim_q;
  logic [LIM_W-1:0]  table_limit_q;
  logic              out_valid_q;

  // datapath registers
  logic [LIM_W-1:0]    lim_q, lim_d;
  logic [LIM_W-1:0]    i_q, i_d;
  logic [LIM_W-1:0]    j_q, j_d;
  logic [2*ADDR_W-1:0] prod_q, prod_d;
  logic [ADDR_W-1:0]   qn_q;
  logic [ADDR_W-1:0]   rd_data_q;
  logic [ADDR_W-1:0]   mem_q [DEPTH];

  logic [ADDR_W-1:0] out_factor_q, out_factor_d;
  logic              out_prime_q, out_prime_d;
  logic [1:0]        out_status_q, out_status_d;

  ctrl_t             cw;
  logic              in_acc;
  logic              emit_ok;
  logic              out_load;
  logic              cond_true;
  logic              cfg_we;
  logic              i_lt_lim, j_ge_lim, sq_ge_lim, rd_nz;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa, mem_wd, rd_addr;

  // configuration access
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {{(32-LIM_W){1'b0}}, table_limit_q};

  // handshakes
  assign s_axis_tready = (upc_q == UPC_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign emit_ok       = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_prime_q, out_factor_q};
  assign m_axis_tuser  = out_status_q;

  // microcode fetch and flags
  assign cw        = ucode_rom(upc_q);
  assign i_lt_lim  = (i_q < lim_q);
  assign j_ge_lim  = (j_q >= lim_q);
  assign sq_ge_lim = (prod_q >= {{(2*ADDR_W-LIM_W){1'b0}}, lim_q});
  assign rd_nz     = (rd_data_q != '0);

  // branch condition
  always_comb begin
    case (cw.cond)
      C_I_LT_LIM:  cond_true = i_lt_lim;
      C_I_GE_LIM:  cond_true = !i_lt_lim;
      C_RD_NZ:     cond_true = rd_nz;
      C_SQ_GE_LIM: cond_true = sq_ge_lim;
      C_J_GE_LIM:  cond_true = j_ge_lim;
      C_JUMP:      cond_true = 1'b1;
      C_EMIT:      cond_true = emit_ok;
      default:     cond_true = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    case (cw.cond)
      C_ITEM: begin
        if (!in_acc) begin
          upc_d = upc_q;
        end else if (s_axis_tuser[0] == OP_BUILD) begin
          upc_d = UPC_CLR;
        end else begin
          upc_d = UPC_QRES;
        end
      end
      C_EMIT:  upc_d = emit_ok ? cw.target : upc_q;
      C_NEXT:  upc_d = upc_q + upc_t'(1);
      default: upc_d = cond_true ? cw.target : upc_q + upc_t'(1);
    endcase
  end

  // datapath actions
  always_comb begin
    i_d          = i_q;
    j_d          = j_q;
    prod_d       = prod_q;
    lim_d        = lim_q;
    mem_we       = 1'b0;
    mem_wa       = i_q[ADDR_W-1:0];
    mem_wd       = '0;
    rd_addr      = s_axis_tdata[ADDR_W-1:0];
    out_load     = 1'b0;
    out_factor_d = '0;
    out_prime_d  = 1'b0;
    out_status_d = ST_BUILT;
    case (cw.act)
      A_NONE: begin
        if (in_acc) begin
          lim_d = (table_limit_q > MAX_LIMIT) ? MAX_LIMIT : table_limit_q;
          i_d   = '0;
        end
      end
      A_CLR: begin
        mem_we = i_lt_lim;
        i_d    = i_q + LIM_W'(1);
      end
      A_I2: begin
        i_d = LIM_W'(2);
      end
      A_RDI: begin
        rd_addr = i_q[ADDR_W-1:0];
        prod_d  = (2*ADDR_W)'(i_q[ADDR_W-1:0]) * (2*ADDR_W)'(i_q[ADDR_W-1:0]);
      end
      A_WRI: begin
        mem_we = 1'b1;
        mem_wd = i_q[ADDR_W-1:0];
      end
      A_JSQ: begin
        j_d = prod_q[LIM_W-1:0];
      end
      A_RDJ: begin
        rd_addr = j_q[ADDR_W-1:0];
      end
      A_MARK: begin
        mem_we = !rd_nz;
        mem_wa = j_q[ADDR_W-1:0];
        mem_wd = i_q[ADDR_W-1:0];
        j_d    = j_q + i_q;
      end
      A_INC: begin
        i_d = i_q + LIM_W'(1);
      end
      A_BEMIT: begin
        out_load = emit_ok;
      end
      A_QEMIT: begin
        // keep the read on the queried number while the result waits
        rd_addr  = qn_q;
        out_load = emit_ok;
        if (!built_q) begin
          out_status_d = ST_NOT_BUILT;
        end else if ({1'b0, qn_q} >= built_lim_q) begin
          out_status_d = ST_RANGE;
        end else begin
          out_status_d = ST_OK;
          out_factor_d = rd_data_q;
          out_prime_d  = (qn_q >= ADDR_W'(2)) && (rd_data_q == qn_q);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // sequencer, build status, limit register and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q         <= UPC_IDLE;
      built_q       <= 1'b0;
      built_lim_q   <= '0;
      table_limit_q <= LIMIT_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (cfg_we) begin
        table_limit_q <= pwdata[LIM_W-1:0];
      end
      if (out_load && (cw.act == A_BEMIT)) begin
        built_q     <= 1'b1;
        built_lim_q <= lim_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers and result payload
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    prod_q <= prod_d;
    lim_q  <= lim_d;
    if (in_acc) begin
      qn_q <= s_axis_tdata[ADDR_W-1:0];
    end
    if (out_load) begin
      out_factor_q <= out_factor_d;
      out_prime_q  <= out_prime_d;
      out_status_q <= out_status_d;
    end
  end

  // factor table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // checks
  `SFS_ASSERT(a_write_in_limit, mem_we |-> ({1'b0, mem_wa} < lim_q),
              "table write at or above the build limit")
  `SFS_ASSERT(a_mark_small_prime, (cw.act == A_MARK) |-> (prod_q < {11'd0, lim_q}),
              "marking with a factor whose square reaches the limit")
  `SFS_ASSERT_NEXT(a_build_sets_built, out_load && (cw.act == A_BEMIT),
                   built_q && m_axis_tvalid && (m_axis_tuser == ST_BUILT),
                   "build result without the table marked as built")
  `SFS_ASSERT(a_ok_needs_build, (m_axis_tvalid && (m_axis_tuser == ST_OK)) |-> built_q,
              "lookup answered ok before any build")

endmodule
